@@ sv/multilevel_queue_rr_scheduler_assert.svh @@
// Assertion macros for the multilevel queue scheduler.
// Each macro samples on aclk and is held off while aresetn is low.
`ifndef MULTILEVEL_QUEUE_RR_SCHEDULER_ASSERT_SVH
`define MULTILEVEL_QUEUE_RR_SCHEDULER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MLQRR_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MLQRR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/mlqrr_pkg.sv @@
package mlqrr_pkg;

    // Default sizes
    localparam int MAX_PROCS_DEF = 16;
    localparam int LEVELS_DEF    = 4;

    // Register reset value
    localparam logic [7:0] QUANTUM_RESET = 8'd2;

    // Input word kinds
    localparam logic FUNC_ADMIT = 1'b0;
    localparam logic FUNC_SCHED = 1'b1;

    // Sequencer states
    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_SCAN = 6'b000010,
        ST_READ = 6'b000100,
        ST_CALC = 6'b001000,
        ST_LIFE = 6'b010000,
        ST_OUT  = 6'b100000
    } state_t;

endpackage

@@ sv/multilevel_queue_rr_scheduler.sv @@
// Admit word: no result word; admits may follow back to back.
// Schedule word: scan of up to LEVELS levels (one level per cycle through a shared priority
// encoder), then read, compute and lifetime states for a grant, or straight to the output
// state for an idle tick. s_tready returns the cycle after the result word loads, which
// waits while the output register is full and m_tready is low.
// Reset (synchronous, aresetn low) clears bitmaps, time and last grant; quantum goes to 2.
`include "multilevel_queue_rr_scheduler_assert.svh"

module multilevel_queue_rr_scheduler #(
    parameter int MAX_PROCS = mlqrr_pkg::MAX_PROCS_DEF,
    parameter int LEVELS    = mlqrr_pkg::LEVELS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    // configuration: quantum
    input  logic         cfg_wr_en,
    input  logic [7:0]   cfg_wr_data,
    // input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    // tdata: proc_index[3:0], level[5:4], duration[21:6], arrival_time[53:22], zero pad
    input  logic [55:0]  s_tdata,
    // tuser: func[0]
    input  logic [0:0]   s_tuser,
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    // tdata: proc_index_res[3:0], start_time[35:4], run_length[51:36], finished[52],
    //        context_switch[53], wait_added[85:54], lifetime[117:86], zero pad
    output logic [119:0] m_tdata,
    // tuser: granted[0]
    output logic [0:0]   m_tuser
);

    localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int LVL_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int PRV_W = $clog2(MAX_PROCS + 1);

    // Field unpacking
    logic        in_func;
    logic [3:0]  in_idx;
    logic [1:0]  in_lvl;
    logic [15:0] in_dur;
    logic [31:0] in_arr;

    assign in_func = s_tuser[0];
    assign in_idx  = s_tdata[3:0];
    assign in_lvl  = s_tdata[5:4];
    assign in_dur  = s_tdata[21:6];
    assign in_arr  = s_tdata[53:22];

    // State
    mlqrr_pkg::state_t    state_reg, state_next;
    logic [MAX_PROCS-1:0] ready_reg [LEVELS];
    logic [MAX_PROCS-1:0] skip_reg  [LEVELS];
    logic [15:0]          rem_mem   [MAX_PROCS];
    logic [31:0]          arr_mem   [MAX_PROCS];
    logic [31:0]          stop_mem  [MAX_PROCS];
    logic [31:0]          time_reg;
    logic [PRV_W-1:0]     prev_reg;
    logic [7:0]           quantum_reg;
    logic [LVL_W-1:0]     lvl_reg;
    logic [IDX_W-1:0]     slot_reg;
    logic [15:0]          rem_rd_reg;
    logic [31:0]          arr_rd_reg;
    logic [31:0]          stop_rd_reg;

    // Result holding and output registers
    logic                 res_granted_reg;
    logic [3:0]           res_idx_reg;
    logic [31:0]          res_start_reg;
    logic [15:0]          res_run_reg;
    logic                 res_fin_reg;
    logic                 res_cs_reg;
    logic [31:0]          res_wait_reg;
    logic [31:0]          res_life_reg;
    logic [31:0]          end_reg;
    logic                 m_tvalid_reg;
    logic [119:0]         m_tdata_reg;
    logic                 m_tuser_reg;

    // Handshakes
    logic in_fire;
    logic admit_fire;
    logic admit_ok;
    logic out_load;

    assign s_tready   = (state_reg == mlqrr_pkg::ST_IDLE);
    assign in_fire    = s_tvalid && s_tready;
    assign admit_ok   = (32'(in_idx) < MAX_PROCS) && (32'(in_lvl) < LEVELS);
    assign admit_fire = in_fire && (in_func == mlqrr_pkg::FUNC_ADMIT) && admit_ok;
    assign out_load   = (state_reg == mlqrr_pkg::ST_OUT) && (!m_tvalid_reg || m_tready);

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Lowest set bit of a candidate map
    function automatic logic [IDX_W-1:0] lowest_set(input logic [MAX_PROCS-1:0] v);
        logic [IDX_W-1:0] n;
        n = '0;
        for (int i = MAX_PROCS - 1; i >= 0; i--) begin
            if (v[i]) begin
                n = IDX_W'(i);
            end
        end
        return n;
    endfunction

    // Shared scan unit: one level per cycle
    logic [MAX_PROCS-1:0] cand_raw;
    logic [MAX_PROCS-1:0] cand;
    logic                 cand_none;
    logic                 last_lvl;

    assign cand_raw  = ready_reg[lvl_reg] & ~skip_reg[lvl_reg];
    assign cand_none = (cand_raw == '0);
    assign cand      = cand_none ? ready_reg[lvl_reg] : cand_raw;
    assign last_lvl  = (lvl_reg == LVL_W'(LEVELS - 1));

    // Slice arithmetic
    logic [7:0]  q_eff;
    logic        fin_c;
    logic [15:0] run_c;
    logic [15:0] rem_new_c;

    assign q_eff     = (quantum_reg == 8'd0) ? 8'd1 : quantum_reg;
    assign fin_c     = (rem_rd_reg <= {8'd0, q_eff});
    assign run_c     = fin_c ? rem_rd_reg : {8'd0, q_eff};
    assign rem_new_c = fin_c ? 16'd0 : (rem_rd_reg - {8'd0, q_eff});

    // Sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            mlqrr_pkg::ST_IDLE: begin
                if (in_fire && (in_func == mlqrr_pkg::FUNC_SCHED)) begin
                    state_next = mlqrr_pkg::ST_SCAN;
                end
            end
            mlqrr_pkg::ST_SCAN: begin
                if (cand != '0) begin
                    state_next = mlqrr_pkg::ST_READ;
                end else if (last_lvl) begin
                    state_next = mlqrr_pkg::ST_OUT;
                end
            end
            mlqrr_pkg::ST_READ: state_next = mlqrr_pkg::ST_CALC;
            mlqrr_pkg::ST_CALC: state_next = mlqrr_pkg::ST_LIFE;
            mlqrr_pkg::ST_LIFE: state_next = mlqrr_pkg::ST_OUT;
            mlqrr_pkg::ST_OUT: begin
                if (out_load) begin
                    state_next = mlqrr_pkg::ST_IDLE;
                end
            end
            default: state_next = mlqrr_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mlqrr_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Quantum register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quantum_reg <= mlqrr_pkg::QUANTUM_RESET;
        end else if (cfg_wr_en) begin
            quantum_reg <= cfg_wr_data;
        end
    end

    // Level bitmaps: admit moves a slot, scan clears spent skip marks, slice end updates
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int lv = 0; lv < LEVELS; lv++) begin
                ready_reg[lv] <= '0;
                skip_reg[lv]  <= '0;
            end
        end else if (admit_fire) begin
            for (int lv = 0; lv < LEVELS; lv++) begin
                ready_reg[lv][IDX_W'(in_idx)] <= (lv == 32'(in_lvl));
                skip_reg[lv][IDX_W'(in_idx)]  <= 1'b0;
            end
        end else if (state_reg == mlqrr_pkg::ST_SCAN) begin
            if (cand_none) begin
                skip_reg[lvl_reg] <= '0;
            end
        end else if (state_reg == mlqrr_pkg::ST_CALC) begin
            if (fin_c) begin
                ready_reg[lvl_reg][slot_reg] <= 1'b0;
                skip_reg[lvl_reg][slot_reg]  <= 1'b0;
            end else begin
                skip_reg[lvl_reg][slot_reg]  <= 1'b1;
            end
        end
    end

    // Scan level and granted slot
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lvl_reg  <= '0;
            slot_reg <= '0;
        end else if (in_fire) begin
            lvl_reg <= '0;
        end else if (state_reg == mlqrr_pkg::ST_SCAN) begin
            if (cand != '0) begin
                slot_reg <= lowest_set(cand);
            end else if (!last_lvl) begin
                lvl_reg <= lvl_reg + 1'b1;
            end
        end
    end

    // Per-slot stores: write on admit (remaining and stop time also at slice end), registered read at the granted slot
    always_ff @(posedge aclk) begin
        if (admit_fire) begin
            rem_mem[IDX_W'(in_idx)] <= in_dur;
        end else if (state_reg == mlqrr_pkg::ST_CALC) begin
            rem_mem[slot_reg] <= rem_new_c;
        end
        if (state_reg == mlqrr_pkg::ST_READ) begin
            rem_rd_reg <= rem_mem[slot_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (admit_fire) begin
            arr_mem[IDX_W'(in_idx)] <= in_arr;
        end
        if (state_reg == mlqrr_pkg::ST_READ) begin
            arr_rd_reg <= arr_mem[slot_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (admit_fire) begin
            stop_mem[IDX_W'(in_idx)] <= in_arr;
        end else if (state_reg == mlqrr_pkg::ST_CALC) begin
            stop_mem[slot_reg] <= time_reg + 32'(run_c);
        end
        if (state_reg == mlqrr_pkg::ST_READ) begin
            stop_rd_reg <= stop_mem[slot_reg];
        end
    end

    // Time and last grant
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_reg <= '0;
            prev_reg <= PRV_W'(MAX_PROCS);
        end else if ((state_reg == mlqrr_pkg::ST_SCAN) && (cand == '0) && last_lvl) begin
            time_reg <= time_reg + 32'd1;
        end else if (state_reg == mlqrr_pkg::ST_CALC) begin
            time_reg <= time_reg + 32'(run_c);
            prev_reg <= PRV_W'(slot_reg);
        end
    end

    // Build the result word
    always_ff @(posedge aclk) begin
        if ((state_reg == mlqrr_pkg::ST_SCAN) && (cand == '0) && last_lvl) begin
            res_granted_reg <= 1'b0;
            res_idx_reg     <= '0;
            res_start_reg   <= time_reg;
            res_run_reg     <= 16'd1;
            res_fin_reg     <= 1'b0;
            res_cs_reg      <= 1'b0;
            res_wait_reg    <= '0;
            res_life_reg    <= '0;
        end else if (state_reg == mlqrr_pkg::ST_CALC) begin
            res_granted_reg <= 1'b1;
            res_idx_reg     <= 4'(slot_reg);
            res_start_reg   <= time_reg;
            res_run_reg     <= run_c;
            res_fin_reg     <= fin_c;
            res_cs_reg      <= (prev_reg != PRV_W'(slot_reg));
            end_reg         <= time_reg + 32'(run_c);
        end else if (state_reg == mlqrr_pkg::ST_LIFE) begin
            res_wait_reg <= res_start_reg - stop_rd_reg;
            res_life_reg <= res_fin_reg ? (end_reg - arr_rd_reg) : 32'd0;
        end
    end

    // Output register: load when free, drop once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tuser_reg <= res_granted_reg;
            m_tdata_reg <= {2'b00, res_life_reg, res_wait_reg, res_cs_reg, res_fin_reg,
                            res_run_reg, res_start_reg, res_idx_reg};
        end
    end

    // Checks
    logic [15:0] out_run;
    logic        out_fin;

    assign out_run = m_tdata_reg[51:36];
    assign out_fin = m_tdata_reg[52];

    `MLQRR_ASSERT_NEXT(a_sched_starts_scan,
        in_fire && (in_func == mlqrr_pkg::FUNC_SCHED),
        state_reg == mlqrr_pkg::ST_SCAN, "schedule word did not start a scan")
    `MLQRR_ASSERT_SAME(a_idle_tick_shape, m_tvalid_reg && !m_tuser_reg,
        (out_run == 16'd1) && !out_fin, "idle tick word malformed")
    `MLQRR_ASSERT_SAME(a_run_within_quantum, m_tvalid_reg && m_tuser_reg,
        out_run <= {8'd0, q_eff}, "granted run exceeds quantum")
    `MLQRR_ASSERT_SAME(a_grant_is_ready, state_reg == mlqrr_pkg::ST_CALC,
        ready_reg[lvl_reg][slot_reg], "granted slot not ready in its level")

endmodule

@@ tb/multilevel_queue_rr_scheduler_tb.sv @@
module multilevel_queue_rr_scheduler_tb;

    localparam int LEVELS        = mlqrr_pkg::LEVELS_DEF;
    localparam int MAX_PROCS     = mlqrr_pkg::MAX_PROCS_DEF;
    localparam int PHASES        = 6;
    localparam int PHASE_ITEMS   = 108;
    localparam int SETTLE_CYCLES = LEVELS + 8;
    localparam int DRAIN_LIMIT   = 20000;

    // One input word: func travels in tuser, the rest in tdata
    typedef struct packed {
        logic        func;
        logic [3:0]  slot;
        logic [1:0]  lvl;
        logic [15:0] dur;
        logic [31:0] arr;
    } sched_req_t;

    // One result word: granted travels in tuser, the rest in tdata
    typedef struct packed {
        logic        granted;
        logic [3:0]  slot;
        logic [31:0] start;
        logic [15:0] run;
        logic        fin;
        logic        cs;
        logic [31:0] wait_added;
        logic [31:0] life;
    } grant_t;

    typedef struct packed {
        sched_req_t req;
        logic       typed;
        grant_t     want;
    } dir_row_t;

    logic         aclk        = 1'b0;
    logic         aresetn     = 1'b0;
    logic         cfg_wr_en   = 1'b0;
    logic [7:0]   cfg_wr_data = '0;
    logic         s_tvalid    = 1'b0;
    logic         s_tready;
    // tdata: proc_index[3:0], level[5:4], duration[21:6], arrival_time[53:22], zero pad
    logic [55:0]  s_tdata     = '0;
    // tuser: func[0]
    logic [0:0]   s_tuser     = '0;
    logic         m_tvalid;
    logic         m_tready    = 1'b1;
    // tdata: proc_index_res[3:0], start_time[35:4], run_length[51:36], finished[52],
    //        context_switch[53], wait_added[85:54], lifetime[117:86], zero pad
    logic [119:0] m_tdata;
    // tuser: granted[0]
    logic [0:0]   m_tuser;

    // Predicted scheduler state
    logic [15:0] rdy_map    [LEVELS];
    logic [15:0] skip_map   [LEVELS];
    logic [15:0] left_time  [MAX_PROCS];
    logic [31:0] born_at    [MAX_PROCS];
    logic [31:0] stopped_at [MAX_PROCS];
    logic [31:0] clock_now;
    logic [4:0]  last_grant;
    logic [7:0]  quantum_q;

    grant_t      expected_grants [$];
    dir_row_t    dir_tab [$];
    logic [7:0]  phase_quanta [PHASES];

    int unsigned err_count   = 0;
    int unsigned words_sent  = 0;
    int unsigned sched_sent  = 0;
    int unsigned results_got = 0;
    int unsigned idle_ticks  = 0;
    int unsigned completions = 0;
    int unsigned rx_left     = 0;
    bit          burst_mode  = 1'b0;
    string       quanta_tried = "";

    always #5 aclk = ~aclk;

    multilevel_queue_rr_scheduler i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    task automatic report_error(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        err_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report_error($sformatf("result %0d field %s: got 0x%0h, want 0x%0h",
                                   results_got, name, got, want));
        end
    endtask

    // Mostly short gaps, a few long ones
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 80) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 15);
        return $urandom_range(20, 60);
    endfunction

    task automatic reset_prediction();
        for (int lv = 0; lv < LEVELS; lv++) begin
            rdy_map[lv]  = '0;
            skip_map[lv] = '0;
        end
        for (int p = 0; p < MAX_PROCS; p++) begin
            left_time[p]  = '0;
            born_at[p]    = '0;
            stopped_at[p] = '0;
        end
        clock_now  = '0;
        last_grant = 5'(MAX_PROCS);
        quantum_q  = mlqrr_pkg::QUANTUM_RESET;
    endtask

    // Advance the predicted state by one word; return 1 when it yields a result word
    function automatic bit step_scheduler(input sched_req_t r, output grant_t g);
        logic [15:0] cand;
        logic [15:0] bitm;
        logic [15:0] q;
        logic [3:0]  pick;
        logic [31:0] start;
        int          hit_lv;
        bit          found;
        g = '0;
        // Admit: move the slot into its level, dropping any old membership and skip mark
        if (r.func == mlqrr_pkg::FUNC_ADMIT) begin
            bitm = 16'd1 << r.slot;
            for (int lv = 0; lv < LEVELS; lv++) begin
                rdy_map[lv]  &= ~bitm;
                skip_map[lv] &= ~bitm;
            end
            rdy_map[r.lvl]     |= bitm;
            left_time[r.slot]  = r.dur;
            born_at[r.slot]    = r.arr;
            stopped_at[r.slot] = r.arr;
            return 1'b0;
        end
        // Scan levels from the top; a fully skipped level gets its marks cleared
        found  = 1'b0;
        hit_lv = 0;
        pick   = '0;
        for (int lv = 0; lv < LEVELS; lv++) begin
            if (!found) begin
                cand = rdy_map[lv] & ~skip_map[lv];
                if (cand == '0) begin
                    skip_map[lv] = '0;
                    cand = rdy_map[lv];
                end
                if (cand != '0) begin
                    for (int i = MAX_PROCS - 1; i >= 0; i--) begin
                        if (cand[i]) pick = 4'(i);
                    end
                    found  = 1'b1;
                    hit_lv = lv;
                end
            end
        end
        start = clock_now;
        // Nothing ready: take an idle tick
        if (!found) begin
            g.start   = start;
            g.run     = 16'd1;
            clock_now = start + 32'd1;
            return 1'b1;
        end
        q = (quantum_q == '0) ? 16'd1 : {8'd0, quantum_q};
        g.granted    = 1'b1;
        g.slot       = pick;
        g.start      = start;
        g.cs         = (last_grant != {1'b0, pick});
        g.wait_added = start - stopped_at[pick];
        if (left_time[pick] <= q) begin
            g.run                  = left_time[pick];
            g.fin                  = 1'b1;
            rdy_map[hit_lv][pick]  = 1'b0;
            skip_map[hit_lv][pick] = 1'b0;
            left_time[pick]        = '0;
        end else begin
            g.run                  = q;
            skip_map[hit_lv][pick] = 1'b1;
            left_time[pick]        = left_time[pick] - q;
        end
        clock_now        = start + {16'd0, g.run};
        stopped_at[pick] = clock_now;
        if (g.fin) g.life = clock_now - born_at[pick];
        last_grant = {1'b0, pick};
        return 1'b1;
    endfunction

    function automatic dir_row_t admit_row(input logic [3:0] slot, input logic [1:0] lvl,
                                           input logic [15:0] dur, input logic [31:0] arr);
        dir_row_t row;
        row       = '0;
        row.req   = {mlqrr_pkg::FUNC_ADMIT, slot, lvl, dur, arr};
        return row;
    endfunction

    // Schedule word: the unused fields carry junk that the block ignores
    function automatic dir_row_t sched_row(input logic typed, input grant_t want);
        dir_row_t row;
        row       = '0;
        row.req   = {mlqrr_pkg::FUNC_SCHED, 4'($urandom), 2'($urandom), 16'($urandom),
                     32'($urandom)};
        row.typed = typed;
        row.want  = want;
        return row;
    endfunction

    function automatic sched_req_t random_item();
        sched_req_t  r;
        int unsigned pct;
        r     = '0;
        r.slot = 4'($urandom_range(0, MAX_PROCS - 1));
        r.lvl  = 2'($urandom_range(0, LEVELS - 1));
        r.dur  = 16'($urandom);
        r.arr  = $urandom;
        if ($urandom_range(0, 99) < 40) begin
            r.func = mlqrr_pkg::FUNC_ADMIT;
            pct = $urandom_range(0, 99);
            if (pct < 8)       r.dur = 16'd0;
            else if (pct < 12) r.dur = 16'hFFFF;
            else if (pct < 20) r.dur = 16'($urandom);
            else               r.dur = 16'($urandom_range(1, 12));
            pct = $urandom_range(0, 99);
            if (pct < 70)      r.arr = clock_now - $urandom_range(0, 50);
            else if (pct < 90) r.arr = $urandom;
            else               r.arr = 32'hFFFF_FFFF - $urandom_range(0, 8);
        end else begin
            r.func = mlqrr_pkg::FUNC_SCHED;
        end
        return r;
    endfunction

    // Offer one word and wait for its handshake, then book the prediction
    task automatic send_word(input sched_req_t r, input logic typed, input grant_t want);
        grant_t g;
        bit     has;
        s_tvalid <= 1'b1;
        s_tuser  <= r.func;
        s_tdata  <= {2'b00, r.arr, r.dur, r.lvl, r.slot};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        has = step_scheduler(r, g);
        if (has) expected_grants.push_back(typed ? want : g);
        words_sent++;
        if (r.func == mlqrr_pkg::FUNC_SCHED) sched_sent++;
    endtask

    task automatic sender_gap();
        int unsigned gap;
        gap = burst_mode ? 0 : pick_gap();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Hold the sender until every expected result word is in or DRAIN_LIMIT runs out, then let the block settle
    task automatic wait_for_drain();
        int unsigned n;
        n = 0;
        s_tvalid <= 1'b0;
        while (expected_grants.size() != 0 && n < DRAIN_LIMIT) begin
            @(posedge aclk);
            n++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_quantum(input logic [7:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        quantum_q    = value;
        quanta_tried = {quanta_tried, $sformatf(" %0d", value)};
    endtask

    // Result side back-pressure
    always @(posedge aclk) begin
        if (burst_mode) begin
            m_tready <= 1'b1;
            rx_left  <= 0;
        end else if (rx_left != 0) begin
            rx_left <= rx_left - 1;
        end else if (m_tready) begin
            if ($urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                rx_left  <= pick_gap();
            end
        end else begin
            m_tready <= 1'b1;
            rx_left  <= $urandom_range(0, 10);
        end
    end

    // Compare each accepted result word with the oldest prediction
    always @(posedge aclk) begin
        grant_t w;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_grants.size() == 0) begin
                report_error($sformatf("result word with nothing expected: tuser %0h tdata %0h",
                                       m_tuser, m_tdata));
            end else begin
                w = expected_grants.pop_front();
                check_field("granted",        32'(m_tuser[0]),       32'(w.granted));
                check_field("proc_index_res", 32'(m_tdata[3:0]),     32'(w.slot));
                check_field("start_time",     m_tdata[35:4],         w.start);
                check_field("run_length",     32'(m_tdata[51:36]),   32'(w.run));
                check_field("finished",       32'(m_tdata[52]),      32'(w.fin));
                check_field("context_switch", 32'(m_tdata[53]),      32'(w.cs));
                check_field("wait_added",     m_tdata[85:54],        w.wait_added);
                check_field("lifetime",       m_tdata[117:86],       w.life);
                if (!w.granted) idle_ticks++;
                if (w.fin) completions++;
            end
            results_got++;
        end
    end

    initial begin
        #3_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        reset_prediction();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed words, run at the reset quantum
        dir_tab.push_back(sched_row(1'b1, '{1'b0, 4'd0, 32'd0, 16'd1, 1'b0, 1'b0, 32'd0, 32'd0}));
        dir_tab.push_back(sched_row(1'b1, '{1'b0, 4'd0, 32'd1, 16'd1, 1'b0, 1'b0, 32'd0, 32'd0}));
        dir_tab.push_back(admit_row(4'd15, 2'd3, 16'hFFFF, 32'hFFFF_FFFF));
        dir_tab.push_back(admit_row(4'd0, 2'd0, 16'd1, 32'd0));
        // zero duration: finishes at its first grant with run length 0
        dir_tab.push_back(admit_row(4'd5, 2'd0, 16'd0, 32'd2));
        dir_tab.push_back(sched_row(1'b1, '{1'b1, 4'd0, 32'd2, 16'd1, 1'b1, 1'b1, 32'd2, 32'd3}));
        dir_tab.push_back(sched_row(1'b0, '0));
        // arrival at the top of the range: wait wraps
        dir_tab.push_back(sched_row(1'b0, '0));
        dir_tab.push_back(admit_row(4'd7, 2'd1, 16'd5, 32'd10));
        // re-admit at another level
        dir_tab.push_back(admit_row(4'd7, 2'd2, 16'd3, 32'd4));
        dir_tab.push_back(admit_row(4'd8, 2'd2, 16'd4, 32'd0));
        dir_tab.push_back(admit_row(4'd9, 2'd2, 16'd2, 32'd1));
        repeat (7) dir_tab.push_back(sched_row(1'b0, '0));
        // re-admit a skipped slot: it loses its skip mark
        dir_tab.push_back(admit_row(4'd15, 2'd0, 16'd3, 32'd0));
        repeat (3) dir_tab.push_back(sched_row(1'b0, '0));
        dir_tab.push_back(admit_row(4'd3, 2'd1, 16'hAAAA, 32'h5555_5555));
        dir_tab.push_back(sched_row(1'b0, '0));

        foreach (dir_tab[i]) begin
            sender_gap();
            send_word(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].want);
        end

        // Random phases, each at its own quantum
        phase_quanta[0] = 8'd0;
        phase_quanta[1] = 8'd255;
        phase_quanta[2] = 8'd1;
        phase_quanta[3] = 8'($urandom_range(3, 20));
        phase_quanta[4] = 8'($urandom_range(1, 255));
        phase_quanta[5] = 8'd2;
        for (int ph = 0; ph < PHASES; ph++) begin
            wait_for_drain();
            write_quantum(phase_quanta[ph]);
            burst_mode = (ph == 3);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (ph == 1 && k == PHASE_ITEMS / 2) wait_for_drain();
                sender_gap();
                send_word(random_item(), 1'b0, '0);
            end
        end

        wait_for_drain();
        burst_mode = 1'b0;
        if (expected_grants.size() != 0) begin
            report_error($sformatf("%0d result words never arrived", expected_grants.size()));
        end

        $display("Covered %0d input words (%0d schedule), %0d result words,",
                 words_sent, sched_sent, results_got);
        $display("%0d completions, %0d idle ticks; quantum settings: 2 (reset)%s",
                 completions, idle_ticks, quanta_tried);
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
